// File: rtl/core/friction_cone_tangent_basis_assert.svh
// assertion macros for the friction cone tangent basis block
// used by the controller; no other dependencies
`ifndef FRICTION_CONE_TANGENT_BASIS_ASSERT_SVH
`define FRICTION_CONE_TANGENT_BASIS_ASSERT_SVH

// condition holds on every edge outside reset
`define FCTB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// trigger on one edge implies the expectation on the next
`define FCTB_ASSERT_NEXT(label, clk, rst, trig, outcome) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (outcome)) \
      else $error("%m: sequence check failed");

`endif

// File: rtl/core/fctb_pkg.sv
// shared types and constants of the friction cone tangent basis block
// no dependencies
package fctb_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BASES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd3;

   localparam int ONE_Q14    = 16384;
   localparam int ROOT_STEPS = 16;
   localparam int DIV_STEPS  = 15;

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Z = 2'd2;

   typedef struct packed {
      logic       load;
      logic       square;
      logic       select;
      logic       root_step;
      logic       div_start;
      logic       div_step;
      logic       div_store;
      logic [1:0] comp;
      logic       rot_mul;
      logic       rot_sum;
   } cmd_type;

endpackage

// File: rtl/core/fctb_datapath.sv
// datapath: squares, bit-serial square root, restoring divider, rotation lanes
// depends on fctb_pkg
module fctb_datapath (
   input  logic                  clock,
   input  fctb_pkg::cmd_type     cmd,
   input  logic signed [15:0]    normal_x,
   input  logic signed [15:0]    normal_y,
   input  logic signed [15:0]    normal_z,
   input  logic signed [15:0]    step_cosine,
   input  logic signed [15:0]    step_sine,
   input  logic [14:0]           degenerate_threshold,
   output logic signed [15:0]    basis_x,
   output logic signed [15:0]    basis_y,
   output logic signed [15:0]    basis_z
);
   import fctb_pkg::*;

   logic signed [15:0] nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic [31:0]        s1_ff, s2_ff, s1_in, s2_in;
   logic [29:0]        thr2_ff, thr2_in;
   logic signed [16:0] t_ff [3];
   logic signed [16:0] t_in [3];
   logic [31:0]        rem_ff, rem_in, root_ff, root_in;
   logic [30:0]        bit_ff, bit_in;
   logic [16:0]        dr_ff, dr_in;
   logic [14:0]        dn_ff, dn_in, dq_ff, dq_in;
   logic signed [15:0] v_ff [3];
   logic signed [15:0] v_in [3];
   logic signed [32:0] cr_ff [3];
   logic signed [32:0] cr_in [3];
   logic signed [31:0] vc_ff [3];
   logic signed [31:0] vc_in [3];

   logic signed [31:0] sq_x, sq_y, sq_z;
   logic [31:0]        root_sum;
   logic [15:0]        len;
   logic [16:0]        mag;
   logic [31:0]        nsum;
   logic [17:0]        trial;
   logic [17:0]        dsor;
   logic signed [15:0] qs;
   logic signed [31:0] pa [3];
   logic signed [31:0] pb [3];
   logic signed [48:0] ps [3];
   logic signed [49:0] xs [3];

   function automatic logic signed [15:0] round_sat(input logic signed [49:0] x);
      logic [49:0] m;
      logic [49:0] rs;
      logic [21:0] q;
      logic [14:0] c;
      m  = x[49] ? 50'(-x) : 50'(x);
      rs = m + (50'd1 << 27);
      q  = rs[49:28];
      c  = (q > 22'(ONE_Q14)) ? 15'(ONE_Q14) : q[14:0];
      return x[49] ? -$signed({1'b0, c}) : $signed({1'b0, c});
   endfunction

   assign len = root_ff[15:0];

   always_comb begin
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff;
      s1_in = s1_ff; s2_in = s2_ff; thr2_in = thr2_ff;
      rem_in = rem_ff; root_in = root_ff; bit_in = bit_ff;
      dr_in = dr_ff; dn_in = dn_ff; dq_in = dq_ff;
      for (int i = 0; i < 3; i++) begin
         t_in[i]  = t_ff[i];
         v_in[i]  = v_ff[i];
         cr_in[i] = cr_ff[i];
         vc_in[i] = vc_ff[i];
      end

      sq_x = nx_ff * nx_ff;
      sq_y = ny_ff * ny_ff;
      sq_z = nz_ff * nz_ff;
      root_sum = root_ff + {1'b0, bit_ff};
      mag   = t_ff[cmd.comp][16] ? 17'(-t_ff[cmd.comp]) : 17'(t_ff[cmd.comp]);
      nsum  = {mag, 15'b0} + {16'b0, len};
      trial = {dr_ff, dn_ff[14]};
      dsor  = {1'b0, len, 1'b0};
      qs    = $signed({1'b0, dq_ff});

      // cross products n x v, lane by lane
      pa[0] = ny_ff * v_ff[2];  pb[0] = nz_ff * v_ff[1];
      pa[1] = nz_ff * v_ff[0];  pb[1] = nx_ff * v_ff[2];
      pa[2] = nx_ff * v_ff[1];  pb[2] = ny_ff * v_ff[0];
      for (int i = 0; i < 3; i++) begin
         ps[i] = cr_ff[i] * step_sine;
         xs[i] = {ps[i][48], ps[i]} + {{4{vc_ff[i][31]}}, vc_ff[i], 14'b0};
      end

      if (cmd.load) begin
         nx_in = normal_x; ny_in = normal_y; nz_in = normal_z;
      end
      if (cmd.square) begin
         s1_in   = $unsigned(sq_x) + $unsigned(sq_y);
         s2_in   = $unsigned(sq_y) + $unsigned(sq_z);
         thr2_in = degenerate_threshold * degenerate_threshold;
      end
      if (cmd.select) begin
         // fall back to x cross n when z cross n is too short
         if (s1_ff < {2'b0, thr2_ff}) begin
            t_in[0] = '0;
            t_in[1] = -$signed({nz_ff[15], nz_ff});
            t_in[2] = $signed({ny_ff[15], ny_ff});
            rem_in  = s2_ff;
         end else begin
            t_in[0] = -$signed({ny_ff[15], ny_ff});
            t_in[1] = $signed({nx_ff[15], nx_ff});
            t_in[2] = '0;
            rem_in  = s1_ff;
         end
         root_in = '0;
         bit_in  = 31'd1 << 30;
      end
      if (cmd.root_step) begin
         if (rem_ff >= root_sum) begin
            rem_in  = rem_ff - root_sum;
            root_in = (root_ff >> 1) + {1'b0, bit_ff};
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
      if (cmd.div_start) begin
         // numerator mag*2^15 + len, top part below the divisor
         dr_in = nsum[31:15];
         dn_in = nsum[14:0];
         dq_in = '0;
      end
      if (cmd.div_step) begin
         if (trial >= dsor) begin
            dr_in = 17'(trial - dsor);
            dq_in = {dq_ff[13:0], 1'b1};
         end else begin
            dr_in = trial[16:0];
            dq_in = {dq_ff[13:0], 1'b0};
         end
         dn_in = dn_ff << 1;
      end
      if (cmd.div_store) begin
         if (len == '0) v_in[cmd.comp] = '0;
         else v_in[cmd.comp] = t_ff[cmd.comp][16] ? -qs : qs;
      end
      if (cmd.rot_mul) begin
         for (int i = 0; i < 3; i++) begin
            cr_in[i] = $signed({pa[i][31], pa[i]}) - $signed({pb[i][31], pb[i]});
            vc_in[i] = v_ff[i] * step_cosine;
         end
      end
      if (cmd.rot_sum) begin
         for (int i = 0; i < 3; i++) v_in[i] = round_sat(xs[i]);
      end
   end

   always_ff @(posedge clock) begin
      nx_ff <= nx_in; ny_ff <= ny_in; nz_ff <= nz_in;
      s1_ff <= s1_in; s2_ff <= s2_in; thr2_ff <= thr2_in;
      rem_ff <= rem_in; root_ff <= root_in; bit_ff <= bit_in;
      dr_ff <= dr_in; dn_ff <= dn_in; dq_ff <= dq_in;
      for (int i = 0; i < 3; i++) begin
         t_ff[i]  <= t_in[i];
         v_ff[i]  <= v_in[i];
         cr_ff[i] <= cr_in[i];
         vc_ff[i] <= vc_in[i];
      end
   end

   assign basis_x = v_ff[0];
   assign basis_y = v_ff[1];
   assign basis_z = v_ff[2];

endmodule

// File: rtl/core/fctb_control.sv
// controller: sequences square, root, divide and rotation steps, drives handshakes
// depends on fctb_pkg and friction_cone_tangent_basis_assert.svh
`include "friction_cone_tangent_basis_assert.svh"

module fctb_control #(
   parameter int MAX_BASES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic              rsp_tlast,
   output logic [3:0]        rsp_index,
   input  logic [4:0]        num_bases,
   output fctb_pkg::cmd_type cmd
);
   import fctb_pkg::*;

   localparam int CW = $clog2(MAX_BASES + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SQUARE = 4'd1;
   localparam logic [3:0] S_SELECT = 4'd2;
   localparam logic [3:0] S_ROOT   = 4'd3;
   localparam logic [3:0] S_DSTART = 4'd4;
   localparam logic [3:0] S_DSTEP  = 4'd5;
   localparam logic [3:0] S_DSTORE = 4'd6;
   localparam logic [3:0] S_EMIT   = 4'd7;
   localparam logic [3:0] S_RMUL   = 4'd8;
   localparam logic [3:0] S_RSUM   = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [1:0]    comp_ff, comp_in;
   logic [CW-1:0] k_ff, k_in, count_ff, count_in;
   logic [CW-1:0] count_clamped;
   logic [8:0]    cmd_flags;

   always_comb begin
      if (num_bases == 5'd0) count_clamped = CW'(1);
      else if (32'(num_bases) > MAX_BASES) count_clamped = CW'(MAX_BASES);
      else count_clamped = CW'(num_bases);
   end

   assign rsp_tlast = (k_ff == count_ff - CW'(1));
   assign rsp_index = 4'(k_ff);

   assign cmd_flags = {cmd.load, cmd.square, cmd.select, cmd.root_step, cmd.div_start,
                       cmd.div_step, cmd.div_store, cmd.rot_mul, cmd.rot_sum};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      k_in     = k_ff;
      count_in = count_ff;
      cmd      = '0;
      cmd.comp = comp_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               count_in = count_clamped;
               k_in     = '0;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_SELECT;
         end
         S_SELECT: begin
            cmd.select = 1'b1;
            cnt_in     = '0;
            state_in   = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 4'd1;
            if (cnt_ff == 4'(ROOT_STEPS - 1)) begin
               comp_in  = COMP_X;
               state_in = S_DSTART;
            end
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            cnt_in        = '0;
            state_in      = S_DSTEP;
         end
         S_DSTEP: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 4'd1;
            if (cnt_ff == 4'(DIV_STEPS - 1)) state_in = S_DSTORE;
         end
         S_DSTORE: begin
            cmd.div_store = 1'b1;
            if (comp_ff == COMP_Z) begin
               state_in = S_EMIT;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_DSTART;
            end
         end
         S_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (rsp_tlast) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = S_RMUL;
               end
            end
         end
         S_RMUL: begin
            cmd.rot_mul = 1'b1;
            state_in    = S_RSUM;
         end
         S_RSUM: begin
            cmd.rot_sum = 1'b1;
            state_in    = S_EMIT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         comp_ff  <= COMP_X;
         k_ff     <= '0;
         count_ff <= CW'(1);
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
         k_ff     <= k_in;
         count_ff <= count_in;
      end
   end

   `FCTB_ASSERT(a_no_accept_while_emitting, clock, reset, !(req_tready && rsp_tvalid))
   `FCTB_ASSERT(a_one_command, clock, reset, $onehot0(cmd_flags))
   `FCTB_ASSERT(a_index_in_range, clock, reset, k_ff < count_ff)
   `FCTB_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, req_tready)
   `FCTB_ASSERT_NEXT(a_rotate_after_take, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, cmd.rot_mul)

endmodule

// File: rtl/core/friction_cone_tangent_basis.sv
// friction cone tangent basis: after an item is accepted the first result is presented once
// square, select, 16 square root steps and a divider start, steps and store for x, y, z
// are done; each later direction is presented after the previous one is taken (multiply, sum)
// a new item is taken the cycle after the last direction of the set is taken
// synchronous active-high reset: controller idle, registers 4, 0, 16384, 1
// depends on fctb_pkg, fctb_control, fctb_datapath
module friction_cone_tangent_basis #(
   parameter int MAX_BASES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [47:0]                      req_tdata,  // normal_x, normal_y, normal_z
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [47:0]                      rsp_tdata,  // basis_x, basis_y, basis_z
   output logic [3:0]                       rsp_tuser,  // basis_index
   output logic                             rsp_tlast,  // last_basis
   input  logic                             csr_we,
   input  logic [fctb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fctb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fctb_pkg::*;

   logic [4:0]         num_bases_ff, num_bases_in;
   logic signed [15:0] step_cos_ff, step_cos_in, step_sin_ff, step_sin_in;
   logic [14:0]        thr_ff, thr_in;
   cmd_type            cmd;
   logic signed [15:0] basis_x, basis_y, basis_z;

   always_comb begin
      num_bases_in = num_bases_ff;
      step_cos_in  = step_cos_ff;
      step_sin_in  = step_sin_ff;
      thr_in       = thr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NUM_BASES: num_bases_in = csr_wdata[4:0];
            CSR_STEP_COS:  step_cos_in  = $signed(csr_wdata);
            CSR_STEP_SIN:  step_sin_in  = $signed(csr_wdata);
            CSR_THRESHOLD: thr_in       = csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bases_ff <= 5'd4;
         step_cos_ff  <= 16'sd0;
         step_sin_ff  <= 16'(ONE_Q14);
         thr_ff       <= 15'd1;
      end else begin
         num_bases_ff <= num_bases_in;
         step_cos_ff  <= step_cos_in;
         step_sin_ff  <= step_sin_in;
         thr_ff       <= thr_in;
      end
   end

   fctb_control #(
      .MAX_BASES(MAX_BASES)
   ) u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_index  (rsp_tuser),
      .num_bases  (num_bases_ff),
      .cmd        (cmd)
   );

   fctb_datapath u_datapath (
      .clock                (clock),
      .cmd                  (cmd),
      .normal_x             ($signed(req_tdata[15:0])),
      .normal_y             ($signed(req_tdata[31:16])),
      .normal_z             ($signed(req_tdata[47:32])),
      .step_cosine          (step_cos_ff),
      .step_sine            (step_sin_ff),
      .degenerate_threshold (thr_ff),
      .basis_x              (basis_x),
      .basis_y              (basis_y),
      .basis_z              (basis_z)
   );

   assign rsp_tdata = {basis_z, basis_y, basis_x};

endmodule

// File: sim/tb_friction_cone_tangent_basis.sv
// self-checking testbench for friction_cone_tangent_basis: normals in, tangent sets out
// predicts each direction set internally; depends on fctb_pkg and the block's rtl
module tb_friction_cone_tangent_basis;
   import fctb_pkg::*;

   typedef struct {
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic signed [15:0] bz;
      logic [3:0]         index;
      logic               last;
   } basis_dir_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [47:0]           req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [47:0]           rsp_tdata;
   logic [3:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // shadow of the block's registers
   logic [4:0]         cfg_count;
   logic signed [15:0] cfg_cos;
   logic signed [15:0] cfg_sin;
   logic [14:0]        cfg_thr;

   basis_dir_type pending_dirs[$];
   int error_count;
   int normals_sent;
   int dirs_seen;
   int send_idle;
   int recv_stall;
   int cos_tab[1:16];
   int sin_tab[1:16];

   friction_cone_tangent_basis u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #40_000_000;
      $display("friction_cone_tangent_basis regression: fail");
      $finish;
   end

   function automatic longint sat_unit(input longint v);
      if (v > ONE_Q14) return ONE_Q14;
      if (v < -ONE_Q14) return -ONE_Q14;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned s);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint scale_q28(input longint a);
      longint unsigned mag;
      longint q;
      mag = (a < 0) ? -a : a;
      q = longint'((mag + (64'd1 << 27)) >> 28);
      return (a < 0) ? -q : q;
   endfunction

   // expected direction set for one normal under the current registers
   task automatic predict_bases(input logic [47:0] d);
      longint nx, ny, nz, len, cx, cy, cz, cnt, q, mag;
      longint t[3];
      longint v[3];
      longint unsigned s;
      basis_dir_type e;
      nx = longint'($signed(d[15:0]));
      ny = longint'($signed(d[31:16]));
      nz = longint'($signed(d[47:32]));
      cnt = cfg_count;
      if (cnt < 1) cnt = 1;
      if (cnt > 16) cnt = 16;
      t[0] = -ny; t[1] = nx; t[2] = 0;
      s = t[0] * t[0] + t[1] * t[1];
      if (s < longint'(cfg_thr) * longint'(cfg_thr)) begin
         t[0] = 0; t[1] = -nz; t[2] = ny;
         s = t[1] * t[1] + t[2] * t[2];
      end
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         if (len == 0) begin
            v[i] = 0;
         end else begin
            mag = (t[i] < 0) ? -t[i] : t[i];
            q = (mag * 2 * ONE_Q14 + len) / (2 * len);
            v[i] = sat_unit((t[i] < 0) ? -q : q);
         end
      end
      for (longint k = 0; k < cnt; k++) begin
         if (k > 0) begin
            cx = ny * v[2] - nz * v[1];
            cy = nz * v[0] - nx * v[2];
            cz = nx * v[1] - ny * v[0];
            v[0] = sat_unit(scale_q28(v[0] * cfg_cos * ONE_Q14 + cx * cfg_sin));
            v[1] = sat_unit(scale_q28(v[1] * cfg_cos * ONE_Q14 + cy * cfg_sin));
            v[2] = sat_unit(scale_q28(v[2] * cfg_cos * ONE_Q14 + cz * cfg_sin));
         end
         e.bx = v[0][15:0];
         e.by = v[1][15:0];
         e.bz = v[2][15:0];
         e.index = k[3:0];
         e.last = (k + 1 == cnt);
         pending_dirs.push_back(e);
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // result side: random stalls and field-by-field compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            dirs_seen++;
            if (pending_dirs.size() == 0) begin
               report_mismatch("unexpected direction, index", rsp_tuser, -1);
            end else begin
               basis_dir_type e;
               e = pending_dirs.pop_front();
               if ($signed(rsp_tdata[15:0]) !== e.bx)
                  report_mismatch("basis_x", $signed(rsp_tdata[15:0]), e.bx);
               if ($signed(rsp_tdata[31:16]) !== e.by)
                  report_mismatch("basis_y", $signed(rsp_tdata[31:16]), e.by);
               if ($signed(rsp_tdata[47:32]) !== e.bz)
                  report_mismatch("basis_z", $signed(rsp_tdata[47:32]), e.bz);
               if (rsp_tuser !== e.index) report_mismatch("basis_index", rsp_tuser, e.index);
               if (rsp_tlast !== e.last) report_mismatch("last_basis", rsp_tlast, e.last);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // called at a rising edge; leaves tvalid high after the item is taken
   task automatic send_normal(input logic [15:0] nx, input logic [15:0] ny,
                              input logic [15:0] nz);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {nz, ny, nx};
      do @(posedge clock); while (!req_tready);
      predict_bases({nz, ny, nx});
      normals_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_dirs.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // registers only change with the block idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_NUM_BASES: cfg_count = val[4:0];
         CSR_STEP_COS:  cfg_cos   = val;
         CSR_STEP_SIN:  cfg_sin   = val;
         CSR_THRESHOLD: cfg_thr   = val[14:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_even_steps(input int n);
      write_reg(CSR_NUM_BASES, 16'(n));
      write_reg(CSR_STEP_COS, 16'(cos_tab[n]));
      write_reg(CSR_STEP_SIN, 16'(sin_tab[n]));
   endtask

   task automatic test_reset_values;
      send_normal(16'sd0, 16'sd0, 16'sd16384);
      send_normal(16'sd16384, 16'sd0, 16'sd0);
      send_normal(16'sd0, 16'sd16384, 16'sd0);
      send_normal(-16'sd16384, -16'sd16384, -16'sd16384);
      send_normal(16'sd0, 16'sd0, 16'sd0);          // zero tangent on both axes
      send_normal(16'sd1, 16'sd0, 16'sd16384);      // length exactly at threshold
      send_normal(16'h7fff, 16'h8000, 16'h7fff);    // off-range components
      send_normal(16'h8000, 16'h7fff, 16'h8000);
      send_normal(16'sd9459, 16'sd9459, 16'sd9459);
      drain();
   endtask

   task automatic test_register_extremes;
      write_reg(CSR_THRESHOLD, 16'd16384);          // x-axis fallback when the xy length is below 16384
      write_reg(CSR_NUM_BASES, 16'd0);              // count of zero acts as one
      send_normal(16'sd11585, 16'sd0, 16'sd11585);
      send_normal(16'sd16384, 16'sd0, 16'sd0);      // xy length equals the threshold, so no fallback
      drain();
      write_reg(CSR_THRESHOLD, 16'h7fff);
      write_reg(CSR_NUM_BASES, 16'd31);             // clamps to sixteen
      write_reg(CSR_STEP_COS, 16'h8000);
      write_reg(CSR_STEP_SIN, 16'h7fff);
      send_normal(16'sd0, 16'sd16384, 16'sd0);
      send_normal(16'h7fff, 16'h7fff, 16'h8000);
      drain();
      write_reg(CSR_THRESHOLD, 16'd0);
      write_reg(CSR_NUM_BASES, 16'd17);
      write_reg(CSR_STEP_COS, 16'sd16384);
      write_reg(CSR_STEP_SIN, -16'sd16384);
      send_normal(16'sd100, -16'sd50, 16'sd16383);
      send_normal(16'sd0, 16'sd0, 16'sd0);
      drain();
      write_reg(CSR_THRESHOLD, 16'd1);
      set_even_steps(16);
      send_normal(16'sd8192, 16'sd8192, 16'sd11585);
      drain();
      set_even_steps(1);
      write_reg(CSR_THRESHOLD, 16'd20000);          // value fits the 15-bit field
      send_normal(16'sd0, 16'sd3, 16'sd16384);
      send_normal(-16'sd5000, 16'sd7000, 16'sd14000);
      drain();
   endtask

   function automatic logic [15:0] rand_comp(input int mode);
      if (mode == 0) return 16'($urandom_range(65535));
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   task automatic test_random_phase(input int items, input int idle, input int stall);
      int mode;
      logic [15:0] a, b, c;
      send_idle  = idle;
      recv_stall = stall;
      // small sets mostly, the full sixteen now and then
      if ($urandom_range(3) == 0) set_even_steps(16);
      else set_even_steps($urandom_range(1, 6));
      if ($urandom_range(4) == 0) begin
         write_reg(CSR_STEP_COS, 16'($urandom_range(65535)));
         write_reg(CSR_STEP_SIN, 16'($urandom_range(65535)));
      end
      write_reg(CSR_THRESHOLD, 16'($urandom_range(0, 4000)));
      for (int i = 0; i < items; i++) begin
         mode = $urandom_range(9);
         if (mode < 2) begin
            a = rand_comp(0); b = rand_comp(0); c = rand_comp(0);
         end else if (mode < 7) begin
            a = rand_comp(1); b = rand_comp(1); c = rand_comp(1);
         end else begin
            // close to the z axis, where the fallback decision sits
            a = 16'($signed($urandom_range(600)) - 300);
            b = 16'($signed($urandom_range(600)) - 300);
            c = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
         end
         send_normal(a, b, c);
         if (i == items / 2) drain();
      end
      drain();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      error_count = 0;
      normals_sent = 0;
      dirs_seen = 0;
      send_idle = 0;
      recv_stall = 0;
      cfg_count = 5'd4;
      cfg_cos = 16'sd0;
      cfg_sin = 16'sd16384;
      cfg_thr = 15'd1;
      for (int n = 1; n <= 16; n++) begin
         cos_tab[n] = $rtoi($floor($cos(2.0 * 3.14159265358979 / n) * 16384.0 + 0.5));
         sin_tab[n] = $rtoi($floor($sin(2.0 * 3.14159265358979 / n) * 16384.0 + 0.5));
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_register_extremes();
      test_random_phase(85, 0, 0);
      test_random_phase(85, 86, 0);
      test_random_phase(85, 0, 86);
      test_random_phase(85, 21, 21);
      $display("covered %0d normals and %0d directions over reset, extreme and random",
               normals_sent, dirs_seen);
      $display("register settings, with sender gaps and receiver stalls in four phases");
      if (error_count == 0 && pending_dirs.size() == 0) begin
         $display("friction_cone_tangent_basis regression: pass");
      end else begin
         $display("friction_cone_tangent_basis regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/fctb_pkg.sv
rtl/core/fctb_datapath.sv
rtl/core/fctb_control.sv
rtl/core/friction_cone_tangent_basis.sv
sim/tb_friction_cone_tangent_basis.sv
